[rtl/mtte_pkg.sv]
`default_nettype none

package mtte_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int FIELD_W = 7;
    localparam int POS_W = 3;
    localparam int DAYS_W = 16;
    localparam int HMS_W = 19;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 7'd99;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_BAD_MONTH = 2'd2;

    // Days from 1970-01-01 to 2000-01-01, less the leap days that the
    // quarter term counts for the years before 2000.
    localparam logic [DAYS_W-1:0] DAYS_BASE = 16'd10458;
    localparam logic [31:0] SECS_PER_DAY = 32'd86400;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } mtte_char_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [1:0]  status;
    } mtte_result_t;

    typedef struct packed {
        logic [FIELD_W-1:0] yy;
        logic [FIELD_W-1:0] mon;
        logic [FIELD_W-1:0] dd;
        logic [FIELD_W-1:0] hh;
        logic [FIELD_W-1:0] mi;
        logic [FIELD_W-1:0] ss;
        logic [1:0]         status;
    } mtte_fields_t;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [HMS_W-1:0]  hms;
        logic [1:0]        status;
    } mtte_calc_t;

    function automatic logic [7:0] end_mark(input logic [POS_W-1:0] pos);
        logic [7:0] mark;
        case (pos)
            3'd0, 3'd1: mark = CHAR_SLASH;
            3'd2:       mark = CHAR_COMMA;
            3'd3, 3'd4: mark = CHAR_COLON;
            3'd5:       mark = CHAR_PLUS;
            default:    mark = 8'h00;
        endcase
        return mark;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/mtte_parser.sv]
`default_nettype none

module mtte_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire mtte_pkg::mtte_char_t item,
    output mtte_pkg::mtte_fields_t    job
);

    logic [mtte_pkg::FIELD_W-1:0] field_reg [mtte_pkg::NUM_FIELDS];
    logic [mtte_pkg::FIELD_W-1:0] field_next [mtte_pkg::NUM_FIELDS];
    logic [9:0]                   acc [mtte_pkg::NUM_FIELDS];
    logic [mtte_pkg::POS_W-1:0]   pos_reg;
    logic [mtte_pkg::POS_W-1:0]   pos_next;
    logic                         quote_reg;
    logic                         quote_next;
    logic                         restart;
    logic                         is_digit;
    logic                         delim;
    logic [3:0]                   digit;

    always_comb
    begin
        restart = (item.char_in == mtte_pkg::CHAR_QUOTE) && !quote_reg;
        is_digit = (item.char_in >= mtte_pkg::CHAR_ZERO) &&
                   (item.char_in <= mtte_pkg::CHAR_NINE);
        digit = item.char_in[3:0];
        delim = (pos_reg < mtte_pkg::POS_W'(mtte_pkg::NUM_FIELDS)) &&
                (item.char_in == mtte_pkg::end_mark(pos_reg));
        quote_next = quote_reg || restart;
        if (restart)
        begin
            pos_next = '0;
        end
        else if (delim)
        begin
            pos_next = pos_reg + 3'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
        for (int i = 0; i < mtte_pkg::NUM_FIELDS; i++)
        begin
            acc[i] = {3'b0, field_reg[i]} * 10'd10 + {6'b0, digit};
            if (restart)
            begin
                field_next[i] = '0;
            end
            else if (is_digit && (pos_reg == mtte_pkg::POS_W'(i)))
            begin
                field_next[i] = (acc[i] > {3'b0, mtte_pkg::FIELD_MAX}) ?
                                mtte_pkg::FIELD_MAX : acc[i][mtte_pkg::FIELD_W-1:0];
            end
            else
            begin
                field_next[i] = field_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mtte_pkg::NUM_FIELDS; i++)
            begin
                field_reg[i] <= '0;
            end
            pos_reg <= '0;
            quote_reg <= 1'b0;
        end
        else if (accept)
        begin
            for (int i = 0; i < mtte_pkg::NUM_FIELDS; i++)
            begin
                field_reg[i] <= item.is_last ? '0 : field_next[i];
            end
            pos_reg <= item.is_last ? '0 : pos_next;
            quote_reg <= item.is_last ? 1'b0 : quote_next;
        end
    end

    always_comb
    begin
        job.yy = field_next[0];
        job.mon = field_next[1];
        job.dd = field_next[2];
        job.hh = field_next[3];
        job.mi = field_next[4];
        job.ss = field_next[5];
        if (pos_next < mtte_pkg::POS_W'(mtte_pkg::NUM_FIELDS))
        begin
            job.status = mtte_pkg::STATUS_MISSING;
        end
        else if ((field_next[1] == '0) || (field_next[1] > 7'd12))
        begin
            job.status = mtte_pkg::STATUS_BAD_MONTH;
        end
        else
        begin
            job.status = mtte_pkg::STATUS_OK;
        end
    end

endmodule

`default_nettype wire

[rtl/mtte_days.sv]
`default_nettype none

module mtte_days (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire mtte_pkg::mtte_fields_t job,
    input  wire logic                   take,
    output logic                        can_load,
    output logic                        calc_valid,
    output mtte_pkg::mtte_calc_t        calc
);

    mtte_pkg::mtte_fields_t       fields_reg;
    logic                         fields_valid_reg;
    mtte_pkg::mtte_calc_t         calc_reg;
    mtte_pkg::mtte_calc_t         calc_next;
    logic                         calc_valid_reg;
    logic                         calc_move;
    logic [mtte_pkg::DAYS_W-1:0]  year_days;
    logic [mtte_pkg::DAYS_W-1:0]  quarter;
    logic                         leap_add;

    always_comb
    begin
        calc_move = !calc_valid_reg || take;
        can_load = !fields_valid_reg || calc_move;

        year_days = 16'(fields_reg.yy) * 16'd365;
        quarter = (16'd1999 + 16'(fields_reg.yy)) >> 2;
        leap_add = (fields_reg.yy[1:0] == 2'b00) && (fields_reg.mon > 7'd2);

        calc_next.days = mtte_pkg::DAYS_BASE + year_days + quarter +
                         16'(mtte_pkg::days_before_month(fields_reg.mon[3:0])) +
                         16'(leap_add) + 16'(fields_reg.dd) - 16'd1;
        calc_next.hms = 19'(fields_reg.hh) * 19'd3600 + 19'(fields_reg.mi) * 19'd60 +
                        19'(fields_reg.ss);
        calc_next.status = fields_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_valid_reg <= 1'b0;
            calc_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                fields_valid_reg <= 1'b1;
            end
            else if (calc_move)
            begin
                fields_valid_reg <= 1'b0;
            end
            if (calc_move)
            begin
                calc_valid_reg <= fields_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fields_reg <= job;
        end
        if (calc_move && fields_valid_reg)
        begin
            calc_reg <= calc_next;
        end
    end

    assign calc_valid = calc_valid_reg;
    assign calc = calc_reg;

endmodule

`default_nettype wire

[rtl/modem_timestamp_to_epoch_top.sv]
// Converts a modem clock string of the form "yy/MM/dd,hh:mm:ss+zz" into
// Unix seconds, taking one character per transfer on the char channel.
// The first double quote of a string restarts the parse, digits build the
// current field up to 99, and each field closes on its own delimiter.
// A character transfer with is_last set closes the string and produces
// one transfer on the epoch channel carrying the seconds and a status
// code (ok, missing fields, or month out of range, the latter two with
// zero seconds). Characters without is_last produce nothing.
// One character is taken per cycle while char_stall is low. A result
// passes through three registers: the field register loads at the
// transfer of its last character, then the day and time-of-day
// register, then the output register holding the product with the seconds
// per day. Those three registers form a pipeline, so characters keep
// flowing while a result waits; char_stall rises only when all three hold
// work and epoch_stall is high.
// Reset clears the parse state and empties the pipeline; a stalled result
// holds its value until it is taken.
`default_nettype none

module modem_timestamp_to_epoch_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_stall,
    input  wire mtte_pkg::mtte_char_t   char_data,
    output logic                        epoch_valid,
    input  wire logic                   epoch_stall,
    output mtte_pkg::mtte_result_t      epoch_data
);

    mtte_pkg::mtte_fields_t  job;
    mtte_pkg::mtte_calc_t    calc;
    mtte_pkg::mtte_result_t  out_reg;
    mtte_pkg::mtte_result_t  out_next;
    logic                    out_valid_reg;
    logic                    out_move;
    logic                    can_load;
    logic                    calc_valid;
    logic                    accept;

    assign out_move = !out_valid_reg || !epoch_stall;
    assign char_stall = !can_load;
    assign accept = char_valid && can_load;

    mtte_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (char_data),
        .job    (job)
    );

    mtte_days u_days (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && char_data.is_last),
        .job        (job),
        .take       (out_move),
        .can_load   (can_load),
        .calc_valid (calc_valid),
        .calc       (calc)
    );

    always_comb
    begin
        out_next.status = calc.status;
        if (calc.status == mtte_pkg::STATUS_OK)
        begin
            out_next.epoch_seconds = {16'b0, calc.days} * mtte_pkg::SECS_PER_DAY +
                                     {13'b0, calc.hms};
        end
        else
        begin
            out_next.epoch_seconds = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= calc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move && calc_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign epoch_valid = out_valid_reg;
    assign epoch_data = out_reg;

endmodule

`default_nettype wire
